// File: src/bsc_pkg.sv
// bsc_pkg: shared types, constants and CORDIC arctangent table for the
// bearing steering command block. No dependencies.
`timescale 1ns / 1ps
package bsc_pkg;

    localparam int TABLE_LEN = 24;
    localparam int XW = 60;  // vectoring datapath width (Q.24 scaled 33 bit diffs + growth)
    localparam int ZW = 28;  // angle width, Q.24 radians
    localparam int RW = 34;  // rotation datapath width, Q.30
    localparam logic signed [ZW-1:0] HALF_PI_Q24  = 28'sd26353589;
    localparam logic signed [RW-1:0] INV_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [15:0]   PI_Q13       = 16'sd25736;

    typedef enum logic [1:0] {
        CMD_FORWARD = 2'd0,
        CMD_LEFT    = 2'd1,
        CMD_RIGHT   = 2'd2
    } cmd_t;

    // Item handed from the front (bearing) to the back (motion) part.
    typedef struct packed {
        logic signed [31:0] robot_x;
        logic signed [31:0] robot_y;
        logic signed [15:0] robot_heading;
        logic signed [15:0] bearing;
    } bsc_item_t;

    function automatic logic signed [ZW-1:0] atan_q24(input logic [4:0] i);
        logic signed [ZW-1:0] v;
        case (i)
            5'd0:  v = 28'sd13176795;
            5'd1:  v = 28'sd7778716;
            5'd2:  v = 28'sd4110060;
            5'd3:  v = 28'sd2086331;
            5'd4:  v = 28'sd1047214;
            5'd5:  v = 28'sd524117;
            5'd6:  v = 28'sd262123;
            5'd7:  v = 28'sd131069;
            5'd8:  v = 28'sd65536;
            5'd9:  v = 28'sd32768;
            5'd10: v = 28'sd16384;
            5'd11: v = 28'sd8192;
            5'd12: v = 28'sd4096;
            5'd13: v = 28'sd2048;
            5'd14: v = 28'sd1024;
            5'd15: v = 28'sd512;
            5'd16: v = 28'sd256;
            5'd17: v = 28'sd128;
            5'd18: v = 28'sd64;
            5'd19: v = 28'sd32;
            5'd20: v = 28'sd16;
            5'd21: v = 28'sd8;
            5'd22: v = 28'sd4;
            5'd23: v = 28'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: src/bsc_front.sv
// bsc_front: pipelined CORDIC vectoring, computes the bearing robot-to-ball.
// Depends on bsc_pkg.
`timescale 1ns / 1ps
module bsc_front #(
    parameter int STAGES = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic signed [31:0]        robot_x,
    input  logic signed [31:0]        robot_y,
    input  logic signed [15:0]        robot_heading,
    input  logic signed [31:0]        ball_x,
    input  logic signed [31:0]        ball_y,
    output logic                      out_valid,
    output bsc_pkg::bsc_item_t        out_item
);
    import bsc_pkg::*;

    localparam int NS = (STAGES < TABLE_LEN) ? STAGES : TABLE_LEN;

    // stage 0 registers: prerotated vector
    logic [NS:0]                   v_reg;
    logic signed [XW-1:0]          x_reg [NS+1];
    logic signed [XW-1:0]          y_reg [NS+1];
    logic signed [ZW-1:0]          z_reg [NS+1];
    logic [NS:0]                   zero_reg;
    bsc_item_t                     it_reg [NS+1];
    logic                          fv_reg;
    bsc_item_t                     fi_reg;

    logic signed [32:0]    dx, dy;
    logic signed [XW-1:0]  x0, y0, xs, ys;
    logic signed [ZW-1:0]  z0;
    logic signed [ZW-1:0]  zr;
    logic signed [ZW-1:0]  zc;
    logic signed [15:0]    bear;

    always_comb
    begin
        dx = 33'(ball_x) - 33'(robot_x);
        dy = 33'(ball_y) - 33'(robot_y);
        xs = {{(XW-57){dx[32]}}, dx, 24'd0};
        ys = {{(XW-57){dy[32]}}, dy, 24'd0};
        x0 = xs;
        y0 = ys;
        z0 = '0;
        if (dx[32])
        begin
            if (!dy[32])
            begin
                x0 = ys;
                y0 = -xs;
                z0 = HALF_PI_Q24;
            end
            else
            begin
                x0 = -ys;
                y0 = xs;
                z0 = -HALF_PI_Q24;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= x0;
        y_reg[0]    <= y0;
        z_reg[0]    <= z0;
        zero_reg[0] <= (dx == '0) && (dy == '0);
        it_reg[0]   <= '{robot_x, robot_y, robot_heading, 16'sd0};
    end

    for (genvar i = 0; i < NS; i++)
    begin : g_stage
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else
            begin
                v_reg[i+1] <= v_reg[i];
            end
        end
        always_ff @(posedge clk)
        begin
            zero_reg[i+1] <= zero_reg[i];
            it_reg[i+1]   <= it_reg[i];
            if (y_reg[i] > 0)
            begin
                x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] + atan_q24(5'(i));
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] - atan_q24(5'(i));
            end
        end
    end

    always_comb
    begin
        zr = z_reg[NS] + ZW'(1024);
        zc = zr >>> 11;
        if (zero_reg[NS])
            bear = '0;
        else if (zc > ZW'(PI_Q13))
            bear = PI_Q13;
        else if (zc < -ZW'(PI_Q13))
            bear = -PI_Q13;
        else
            bear = zc[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fv_reg <= 1'b0;
        else
            fv_reg <= v_reg[NS];
    end

    always_ff @(posedge clk)
    begin
        fi_reg <= '{it_reg[NS].robot_x, it_reg[NS].robot_y,
                    it_reg[NS].robot_heading, bear};
    end

    assign out_valid = fv_reg;
    assign out_item  = fi_reg;
endmodule

// File: src/bsc_queue.sv
// bsc_queue: two-entry FIFO between bearing front and motion back.
// Depends on bsc_pkg.
`timescale 1ns / 1ps
module bsc_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  bsc_pkg::bsc_item_t wr_item,
    output logic               rd_valid,
    output bsc_pkg::bsc_item_t rd_item
);
    import bsc_pkg::*;

    // back never stalls: read when not empty
    bsc_item_t   mem_reg [2];
    logic        wp_reg, rp_reg;
    logic [1:0]  cnt_reg, cnt_next;
    logic        rd_en;

    assign rd_en    = cnt_reg != 2'd0;
    assign rd_valid = rd_en;
    assign rd_item  = mem_reg[rp_reg];

    always_comb
    begin
        cnt_next = cnt_reg + 2'(wr_en) - 2'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (wr_en) wp_reg <= ~wp_reg;
            if (rd_en) rp_reg <= ~rp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) mem_reg[wp_reg] <= wr_item;
    end
endmodule

// File: src/bsc_back.sv
// bsc_back: decision plus pipelined CORDIC rotation for the unit step.
// Depends on bsc_pkg.
`timescale 1ns / 1ps
module bsc_back #(
    parameter int STAGES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  bsc_pkg::bsc_item_t in_item,
    input  logic [14:0]        align_threshold,
    output logic               done,
    output logic [1:0]         command,
    output logic signed [15:0] bearing,
    output logic [15:0]        turn_amount,
    output logic signed [31:0] new_x,
    output logic signed [31:0] new_y,
    output logic signed [15:0] new_heading
);
    import bsc_pkg::*;

    localparam int NS = (STAGES < TABLE_LEN) ? STAGES : TABLE_LEN;

    typedef struct packed {
        bsc_item_t   it;
        logic [1:0]  cmd;
        logic [15:0] turn;
        logic [1:0]  quad;   // 0 none, 1 plus, 2 minus
    } ctl_t;

    logic [NS:0]          v_reg;
    ctl_t                 c_reg [NS+1];
    logic signed [RW-1:0] x_reg [NS+1];
    logic signed [RW-1:0] y_reg [NS+1];
    logic signed [ZW-1:0] z_reg [NS+1];

    logic signed [16:0]   diff;
    logic [16:0]          mag;
    ctl_t                 c0;
    logic signed [ZW-1:0] z0;

    always_comb
    begin
        diff = 17'(in_item.bearing) - 17'(in_item.robot_heading);
        mag  = diff[16] ? 17'(-diff) : 17'(diff);
        c0.it   = in_item;
        c0.quad = 2'd0;
        z0 = ZW'(in_item.bearing) <<< 11;
        if (mag < 17'(align_threshold))
        begin
            c0.cmd  = CMD_FORWARD;
            c0.turn = '0;
        end
        else
        begin
            c0.cmd  = (diff > 0) ? CMD_LEFT : CMD_RIGHT;
            c0.turn = mag[15:0];
        end
        if (z0 > HALF_PI_Q24)
        begin
            z0 = z0 - HALF_PI_Q24;
            c0.quad = 2'd1;
        end
        else if (z0 < -HALF_PI_Q24)
        begin
            z0 = z0 + HALF_PI_Q24;
            c0.quad = 2'd2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v_reg[0] <= 1'b0;
        else        v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        c_reg[0] <= c0;
        x_reg[0] <= INV_GAIN_Q30;
        y_reg[0] <= '0;
        z_reg[0] <= z0;
    end

    for (genvar i = 0; i < NS; i++)
    begin : g_stage
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) v_reg[i+1] <= 1'b0;
            else        v_reg[i+1] <= v_reg[i];
        end
        always_ff @(posedge clk)
        begin
            c_reg[i+1] <= c_reg[i];
            if (!z_reg[i][ZW-1])
            begin
                x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] - atan_q24(5'(i));
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] + atan_q24(5'(i));
            end
        end
    end

    ctl_t                 cf;
    logic signed [RW-1:0] cq, sq;
    logic signed [RW-1:0] cr, sr;
    logic signed [33:0]   sx, sy;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        if (v > 34'sh07FFFFFFF)       return 32'sh7FFFFFFF;
        else if (v < -34'sh080000000) return 32'sh80000000;
        else                          return v[31:0];
    endfunction

    always_comb
    begin
        cf = c_reg[NS];
        case (cf.quad)
            2'd1:    begin cq = -y_reg[NS]; sq = x_reg[NS];  end
            2'd2:    begin cq = y_reg[NS];  sq = -x_reg[NS]; end
            default: begin cq = x_reg[NS];  sq = y_reg[NS];  end
        endcase
        cr = (cq + RW'(8192)) >>> 14;
        sr = (sq + RW'(8192)) >>> 14;
        sx = 34'(cf.it.robot_x) + 34'(cr);
        sy = 34'(cf.it.robot_y) + 34'(sr);
    end

    logic               done_reg;
    logic [1:0]         cmd_reg;
    logic signed [15:0] bear_reg, nh_reg;
    logic [15:0]        turn_reg;
    logic signed [31:0] nx_reg, ny_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) done_reg <= 1'b0;
        else        done_reg <= v_reg[NS];
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cf.cmd;
        bear_reg <= cf.it.bearing;
        turn_reg <= cf.turn;
        if (cf.cmd == CMD_FORWARD)
        begin
            nx_reg <= sat32(sx);
            ny_reg <= sat32(sy);
            nh_reg <= cf.it.robot_heading;
        end
        else
        begin
            nx_reg <= cf.it.robot_x;
            ny_reg <= cf.it.robot_y;
            nh_reg <= cf.it.bearing;
        end
    end

    assign done        = done_reg;
    assign command     = cmd_reg;
    assign bearing     = bear_reg;
    assign turn_amount = turn_reg;
    assign new_x       = nx_reg;
    assign new_y       = ny_reg;
    assign new_heading = nh_reg;
endmodule

// File: src/bearing_steering_command_core.sv
// A start passes through the front pipeline, the queue and the back pipeline to done.
// Throughput: one transfer per cycle; busy is never raised, both CORDIC
// units are fully unrolled pipelines with one stage per iteration.
// Results appear on done for one cycle; the receiver cannot stall.
// Reset (async, rst_n low) clears all valid bits and sets align_threshold to 819.
// Depends on bsc_pkg, bsc_front, bsc_queue, bsc_back.
`timescale 1ns / 1ps
module bearing_steering_command_core #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] robot_x,
    input  logic signed [31:0] robot_y,
    input  logic signed [15:0] robot_heading,
    input  logic signed [31:0] ball_x,
    input  logic signed [31:0] ball_y,
    input  logic               cfg_we,
    input  logic [14:0]        cfg_wdata,
    output logic               done,
    output logic [1:0]         command,
    output logic signed [15:0] bearing,
    output logic [15:0]        turn_amount,
    output logic signed [31:0] new_x,
    output logic signed [31:0] new_y,
    output logic signed [15:0] new_heading
);
    import bsc_pkg::*;

    logic [14:0] thr_reg;
    logic        f_valid, q_valid, acc;
    bsc_item_t   f_item, q_item;

    // Both halves run every cycle, so no transfer is ever refused.
    assign busy = 1'b0;
    assign acc  = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= 15'd819;
        else if (cfg_we)
            thr_reg <= cfg_wdata;
    end

    // front: bearing by vectoring CORDIC
    bsc_front #(.STAGES(CORDIC_STAGES)) u_front (
        .clk, .rst_n, .in_valid(acc),
        .robot_x, .robot_y, .robot_heading, .ball_x, .ball_y,
        .out_valid(f_valid), .out_item(f_item)
    );

    // decoupling queue
    bsc_queue u_queue (
        .clk, .rst_n, .wr_en(f_valid), .wr_item(f_item),
        .rd_valid(q_valid), .rd_item(q_item)
    );

    // back: decide and step along bearing
    bsc_back #(.STAGES(CORDIC_STAGES)) u_back (
        .clk, .rst_n, .in_valid(q_valid), .in_item(q_item),
        .align_threshold(thr_reg),
        .done, .command, .bearing, .turn_amount, .new_x, .new_y, .new_heading
    );

    a_cmd_legal: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (command != 2'd3))
        else $error("illegal command");
    a_fwd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && command == CMD_FORWARD) |-> (turn_amount == 16'd0))
        else $error("turn nonzero on forward");
    a_turn_head: assert property (@(posedge clk) disable iff (!rst_n)
        (done && command != CMD_FORWARD) |-> (new_heading == bearing))
        else $error("turn heading mismatch");
endmodule
